// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled during rst.
`define ASSERT_IMPLIES(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, disabled during rst.
`define ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) else $error(msg);

`endif

// ===== src/scat_pkg.sv =====
// Package: marker state type, byte constants and escape lookup for the transcoder.
`timescale 1ns / 1ps

package scat_pkg;

  localparam int MAX_RESULTS = 9;
  localparam int CNT_W       = 4;

  localparam logic [7:0] MARK_FIRST  = 8'hC2;
  localparam logic [7:0] MARK_SECOND = 8'hA7;
  localparam logic [7:0] CHR_ESC     = 8'h1B;
  localparam logic [7:0] CHR_LBRACK  = 8'h5B;
  localparam logic [7:0] CHR_0       = 8'h30;
  localparam logic [7:0] CHR_3       = 8'h33;
  localparam logic [7:0] CHR_9       = 8'h39;
  localparam logic [7:0] CHR_M       = 8'h6D;

  // format code letters
  localparam logic [7:0] CODE_RESET     = 8'h72; // r
  localparam logic [7:0] CODE_BOLD      = 8'h6C; // l
  localparam logic [7:0] CODE_UNDERLINE = 8'h6E; // n
  localparam logic [7:0] CODE_ITALIC    = 8'h6F; // o
  localparam logic [7:0] CODE_STRIKE    = 8'h6D; // m

  // low digit of the color escape, indexed by code value bits [2:0]
  localparam logic [2:0] COLOUR_LOW [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

  typedef enum logic [1:0] {
    MS_IDLE  = 2'd0,
    MS_FIRST = 2'd1,
    MS_FULL  = 2'd2
  } mark_state_t;

  typedef struct packed {
    logic [4:0][7:0] bytes;  // bytes[0] goes out first
    logic [2:0]      len;
  } esc_t;

  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] seq;   // seq[0] goes out first
    logic [CNT_W-1:0]            count;
    mark_state_t                 next;
  } scat_build_t;

  function automatic esc_t code_escape(input logic [7:0] c);
    esc_t       e;
    logic [3:0] idx;
    e          = '0;
    idx        = '0;
    e.bytes[0] = CHR_ESC;
    e.bytes[1] = CHR_LBRACK;
    if (c inside {[8'h30:8'h39], [8'h61:8'h66]}) begin
      idx        = (c inside {[8'h30:8'h39]}) ? 4'(c - 8'h30) : 4'(c - 8'h57);
      e.bytes[2] = idx[3] ? CHR_9 : CHR_3;
      e.bytes[3] = CHR_0 + {5'd0, COLOUR_LOW[idx[2:0]]};
      e.bytes[4] = CHR_M;
      e.len      = 3'd5;
    end else begin
      e.bytes[3] = CHR_M;
      e.len      = 3'd4;
      case (c)
        CODE_RESET:     e.bytes[2] = CHR_0;
        CODE_BOLD:      e.bytes[2] = CHR_0 + 8'd1;
        CODE_UNDERLINE: e.bytes[2] = CHR_0 + 8'd4;
        CODE_ITALIC:    e.bytes[2] = CHR_0 + 8'd3;
        CODE_STRIKE:    e.bytes[2] = CHR_0 + 8'd9;
        default:        e = '0;  // k and unknown codes: dropped
      endcase
    end
    return e;
  endfunction

endpackage

// ===== src/section_code_to_ansi_transcoder_unit.sv =====
// Top level: section-code to ANSI escape transcoder with output shift buffer.
// Latency: first result byte is valid the cycle after its input transaction.
// Throughput: one input per cycle while each input yields at most one byte and
//   the output is not stalled; an input yielding n bytes (up to 9) holds the
//   input side until its last byte leaves; one byte drains per unstalled cycle.
// Reset: clears the marker state and discards any bytes still buffered.
`timescale 1ns / 1ps

module section_code_to_ansi_transcoder_unit (
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_text,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       run_last
);
  import scat_pkg::*;

  // Marker progress: idle, 0xC2 held, or full 0xC2 0xA7 held awaiting code.
  mark_state_t                 state;
  // Result buffer: a shift line, byte 0 is what the output shows.
  logic [MAX_RESULTS-1:0][7:0] buffer;
  logic [CNT_W-1:0]            count;

  scat_build_t res;
  logic        in_take;
  logic        out_take;

  scat_expand u_expand (
    .state       (state),
    .in_byte     (in_byte),
    .end_of_text (end_of_text),
    .res         (res)
  );

  assign out_valid = (count != '0);
  assign out_byte  = buffer[0];
  assign run_last  = (count == CNT_W'(1));
  assign out_take  = out_valid && !out_stall;

  // The buffer can take a new run when it is empty, or when its final byte
  // leaves in this very cycle. Inputs that yield no bytes go through the
  // same path so marker state stays in order.
  assign in_stall = (count > CNT_W'(1)) || (run_last && out_stall);
  assign in_take  = in_valid && !in_stall;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MS_IDLE;
      count <= '0;
    end else begin
      if (in_take) begin
        state <= res.next;
        count <= res.count;
      end else if (out_take) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // payload: load a fresh run, or shift the next byte into place
  always_ff @(posedge clk) begin
    if (in_take) begin
      buffer <= res.seq;
    end else if (out_take) begin
      buffer <= {8'h00, buffer[MAX_RESULTS-1:1]};
    end
  end

endmodule

// ===== src/scat_expand.sv =====
// Expansion logic: one input byte plus marker state to the full output byte run.
`timescale 1ns / 1ps

module scat_expand (
  input  scat_pkg::mark_state_t state,
  input  logic [7:0]            in_byte,
  input  logic                  end_of_text,
  output scat_pkg::scat_build_t res
);
  import scat_pkg::*;

  logic [4:0][7:0] head;
  logic [2:0]      head_len;
  logic [5:0][7:0] tail;
  logic [2:0]      tail_len;
  mark_state_t     ns;
  esc_t            esc;
  logic [3:0]      ti;

  always_comb begin
    head     = '0;
    head_len = '0;
    tail     = '0;
    tail_len = '0;
    ns       = MS_IDLE;
    esc      = code_escape(in_byte);
    res      = '0;
    ti       = '0;

    case (state)
      MS_FIRST: begin
        if (in_byte == MARK_SECOND) begin
          ns = MS_FULL;
        end else if (in_byte == MARK_FIRST) begin
          head[0]  = MARK_FIRST;
          head_len = 3'd1;
          ns       = MS_FIRST;
        end else begin
          head[0]  = MARK_FIRST;
          head[1]  = in_byte;
          head_len = 3'd2;
        end
      end
      MS_FULL: begin
        head     = esc.bytes;
        head_len = esc.len;
      end
      default: begin
        if (in_byte == MARK_FIRST) begin
          ns = MS_FIRST;
        end else begin
          head[0]  = in_byte;
          head_len = 3'd1;
        end
      end
    endcase

    // end of text: flush held marker bytes, then ESC [0m
    if (end_of_text) begin
      case (ns)
        MS_FIRST: begin
          tail[0]  = MARK_FIRST;
          tail[1]  = CHR_ESC;
          tail[2]  = CHR_LBRACK;
          tail[3]  = CHR_0;
          tail[4]  = CHR_M;
          tail_len = 3'd5;
        end
        MS_FULL: begin
          tail[0]  = MARK_FIRST;
          tail[1]  = MARK_SECOND;
          tail[2]  = CHR_ESC;
          tail[3]  = CHR_LBRACK;
          tail[4]  = CHR_0;
          tail[5]  = CHR_M;
          tail_len = 3'd6;
        end
        default: begin
          tail[0]  = CHR_ESC;
          tail[1]  = CHR_LBRACK;
          tail[2]  = CHR_0;
          tail[3]  = CHR_M;
          tail_len = 3'd4;
        end
      endcase
      ns = MS_IDLE;
    end

    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (CNT_W'(i) < {1'b0, head_len}) begin
        res.seq[i] = head[3'(i)];
      end else begin
        ti         = CNT_W'(i) - {1'b0, head_len};
        res.seq[i] = (ti < 4'd6) ? tail[ti[2:0]] : 8'h00;
      end
    end
    res.count = {1'b0, head_len} + {1'b0, tail_len};
    res.next  = ns;
  end

endmodule

// ===== src/scat_checker.sv =====
// Port-level checker for the transcoder, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scat_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       end_of_text,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       run_last
);

  // stalled result holds
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(run_last), "stalled output changed")
  // end of text always yields at least the reset escape
  `ASSERT_NEXT(a_eot_out, in_valid && !in_stall && end_of_text, out_valid, "no output after end of text")
  // mid-run bytes block the input
  `ASSERT_IMPLIES(a_run_blocks, out_valid && !run_last, in_stall, "input taken during a run")
  // backpressure propagates
  `ASSERT_IMPLIES(a_bp, out_valid && out_stall, in_stall, "input taken while output stalled")

endmodule

bind section_code_to_ansi_transcoder_unit scat_checker u_scat_checker (.*);

// ===== verif/testbench.sv =====
// Testbench for the section-code to ANSI transcoder: directed table, random text, scoreboard.
`timescale 1ns / 1ps

module testbench;
  import scat_pkg::*;

  // Run length and the pressure points, counted in random input transactions.
  localparam int RAND_ITEMS   = 430;
  localparam int HOLD_AT      = 100;   // receiver holds off here, sender floods
  localparam int HOLD_CYCLES  = 60;
  localparam int PAUSE_AT     = 260;   // sender waits for a full drain here
  localparam int CALM_AT      = 340;   // no idling on either side from here on
  localparam int DRAIN_CYCLES = 20;    // buffer holds at most 9 bytes
  localparam int CYCLE_LIMIT  = 300000;
  localparam int MAX_REPORTS  = 40;

  // Code letters for well-formed markers; k and the style codes included.
  localparam string CODE_POOL = "0123456789abcdefklmnor";

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte     = 8'h00;
  logic       end_of_text = 1'b0;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  logic [7:0] out_byte;
  logic       run_last;

  section_code_to_ansi_transcoder_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .end_of_text (end_of_text),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .run_last    (run_last)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Transcoding predictor: own copy of the marker state, fills ansi_bytes with
  // the bytes one input transaction is expected to produce, in order.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [7:0] b;
    logic       fin;   // run_last expected on this byte
  } ansi_out_t;

  string colour_text [16] = '{
    "\033[30m", "\033[34m", "\033[32m", "\033[36m",
    "\033[31m", "\033[35m", "\033[33m", "\033[37m",
    "\033[90m", "\033[94m", "\033[92m", "\033[96m",
    "\033[91m", "\033[95m", "\033[93m", "\033[97m"
  };
  localparam string RESET_TEXT = "\033[0m";

  mark_state_t mark_st;
  logic [7:0]  ansi_bytes [$];   // bytes of the current transaction
  ansi_out_t   ansi_expected [$]; // scoreboard: oldest expectation first
  int          err_cnt = 0;
  int          idle_pct = 0;     // chance of an idle burst, both sides
  bit          hold_req = 1'b0;  // asks the receiver for a long hold-off

  // Escape for the code byte after a full marker; empty means dropped (k, unknown).
  function automatic string code_text(input logic [7:0] c);
    if (c >= "0" && c <= "9") return colour_text[c - "0"];
    if (c >= "a" && c <= "f") return colour_text[c - "a" + 10];
    case (c)
      CODE_RESET:     return RESET_TEXT;
      CODE_BOLD:      return "\033[1m";
      CODE_UNDERLINE: return "\033[4m";
      CODE_ITALIC:    return "\033[3m";
      CODE_STRIKE:    return "\033[9m";
      default:        return "";
    endcase
  endfunction

  function automatic void append_text(input string s);
    for (int i = 0; i < s.len(); i++) ansi_bytes.push_back(s[i]);
  endfunction

  function automatic void predict_transcode(input logic [7:0] b, input logic eot);
    ansi_bytes.delete();
    case (mark_st)
      MS_FIRST: begin
        if (b == MARK_SECOND) begin
          mark_st = MS_FULL;
        end else if (b == MARK_FIRST) begin
          // first C2 goes out, the new one is held in its place
          ansi_bytes.push_back(MARK_FIRST);
        end else begin
          ansi_bytes.push_back(MARK_FIRST);
          ansi_bytes.push_back(b);
          mark_st = MS_IDLE;
        end
      end
      MS_FULL: begin
        // code byte always consumed, whatever its value
        append_text(code_text(b));
        mark_st = MS_IDLE;
      end
      default: begin
        if (b == MARK_FIRST) begin
          mark_st = MS_FIRST;
        end else begin
          ansi_bytes.push_back(b);
          mark_st = MS_IDLE;
        end
      end
    endcase
    if (eot) begin
      // a cut-off marker is flushed as plain bytes before the closing reset
      if (mark_st == MS_FIRST) begin
        ansi_bytes.push_back(MARK_FIRST);
      end else if (mark_st == MS_FULL) begin
        ansi_bytes.push_back(MARK_FIRST);
        ansi_bytes.push_back(MARK_SECOND);
      end
      mark_st = MS_IDLE;
      append_text(RESET_TEXT);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table. Rows with a typed result are queued from that text; the
  // rest take the predictor's bytes. Marker state is tracked on every row.
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [7:0] b;
    logic       eot;
    bit         typed;
    string      want;
  } dir_row_t;

  dir_row_t dir_tab [27] = '{
    '{8'h41, 1'b0, 1'b1, "A"},
    '{8'h00, 1'b0, 1'b0, ""},
    '{8'hFF, 1'b0, 1'b1, "\377"},
    '{8'hC2, 1'b0, 1'b0, ""},                  // full marker, lowest color
    '{8'hA7, 1'b0, 1'b0, ""},
    '{8'h30, 1'b0, 1'b1, "\033[30m"},
    '{8'hC2, 1'b0, 1'b0, ""},                  // full marker, highest color
    '{8'hA7, 1'b0, 1'b0, ""},
    '{8'h66, 1'b0, 1'b1, "\033[97m"},
    '{8'hC2, 1'b0, 1'b0, ""},                  // reset code
    '{8'hA7, 1'b0, 1'b0, ""},
    '{8'h72, 1'b0, 1'b1, "\033[0m"},
    '{8'hC2, 1'b0, 1'b0, ""},                  // doubled C2, then k dropped
    '{8'hC2, 1'b0, 1'b0, ""},
    '{8'hA7, 1'b0, 1'b0, ""},
    '{8'h6B, 1'b0, 1'b0, ""},
    '{8'hC2, 1'b0, 1'b0, ""},                  // C2 then plain byte
    '{8'h58, 1'b0, 1'b0, ""},
    '{8'hC2, 1'b0, 1'b0, ""},                  // C2 as code byte, consumed
    '{8'hA7, 1'b0, 1'b0, ""},
    '{8'hC2, 1'b0, 1'b0, ""},
    '{8'hC2, 1'b1, 1'b1, "\302\033[0m"},       // half marker at end of text
    '{8'hC2, 1'b0, 1'b0, ""},
    '{8'hA7, 1'b1, 1'b1, "\302\247\033[0m"},   // full marker at end of text
    '{8'hC2, 1'b0, 1'b0, ""},                  // color on last byte: 9 bytes out
    '{8'hA7, 1'b0, 1'b0, ""},
    '{8'h37, 1'b1, 1'b1, "\033[37m\033[0m"}
  };

  // Drive one transaction at the falling edge, wait for it to be taken, then
  // queue its expected bytes. Returns at the next falling edge.
  task automatic send_byte(input logic [7:0] b, input logic eot, input bit typed,
                           input string want);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_byte     <= b;
    end_of_text <= eot;
    do @(posedge clk); while (in_stall);
    predict_transcode(b, eot);
    if (typed) begin
      ansi_bytes.delete();
      append_text(want);
    end
    foreach (ansi_bytes[i])
      ansi_expected.push_back('{b: ansi_bytes[i], fin: (i == ansi_bytes.size() - 1)});
    @(negedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (err_cnt < MAX_REPORTS)
      $display("ERROR @%0t: %s: got %02h, expected %02h", $time, what, got, want);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Output check: every accepted byte against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    ansi_out_t e;
    if (!rst && out_valid && !out_stall) begin
      if (ansi_expected.size() == 0) begin
        report_mismatch("unexpected output byte", out_byte, 8'h00);
      end else begin
        e = ansi_expected.pop_front();
        if (out_byte !== e.b) report_mismatch("out_byte", out_byte, e.b);
        if (run_last !== e.fin) report_mismatch("run_last", {7'd0, run_last}, {7'd0, e.fin});
      end
    end
  end

  // Receiver: short random stall bursts, plus one long hold-off on request.
  initial begin
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3) - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog.
  int cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: reset, directed table, then random strings of text.
  // ---------------------------------------------------------------------------
  initial begin
    int         sent;
    bit         held;
    bit         paused;
    logic [7:0] text_q [$];
    mark_st = MS_IDLE;
    sent    = 0;
    held    = 1'b0;
    paused  = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    idle_pct = 25;
    foreach (dir_tab[i])
      send_byte(dir_tab[i].b, dir_tab[i].eot, dir_tab[i].typed, dir_tab[i].want);

    while (sent < RAND_ITEMS) begin
      // phase of the run: idling rate and the two pressure points
      if (sent < HOLD_AT)       idle_pct = 25;
      else if (sent < 160)      idle_pct = 0;
      else if (sent < PAUSE_AT) idle_pct = 35;
      else if (sent < CALM_AT)  idle_pct = 15;
      else                      idle_pct = 0;
      if (!held && sent >= HOLD_AT) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && sent >= PAUSE_AT) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        do @(negedge clk); while (ansi_expected.size() != 0);
      end

      // one string: mostly well-formed markers and plain text, some breakage
      text_q.delete();
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: text_q.push_back(8'($urandom_range(0, 255)));
          4, 5, 6: begin
            text_q.push_back(MARK_FIRST);
            text_q.push_back(MARK_SECOND);
            text_q.push_back(CODE_POOL[$urandom_range(0, CODE_POOL.len() - 1)]);
          end
          7: begin
            text_q.push_back(MARK_FIRST);
            text_q.push_back(MARK_SECOND);
            text_q.push_back(8'($urandom_range(0, 255)));
          end
          8: begin
            text_q.push_back(MARK_FIRST);
            text_q.push_back(8'($urandom_range(0, 255)));
          end
          default: begin
            // bare marker; cut off when it lands at the end of the string
            text_q.push_back(MARK_FIRST);
            if ($urandom_range(0, 1) == 1) text_q.push_back(MARK_SECOND);
          end
        endcase
      end
      foreach (text_q[k]) begin
        send_byte(text_q[k], (k == text_q.size() - 1), 1'b0, "");
        sent++;
      end
    end
    in_valid <= 1'b0;

    while (ansi_expected.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/scat_pkg.sv
src/scat_expand.sv
src/section_code_to_ansi_transcoder_unit.sv
src/scat_checker.sv
verif/testbench.sv
